// ===== rtl/core/hvt_pkg.sv =====
// Shared types and constants of the H/V timer, IRQ and NMI unit.
package hvt_pkg;

	localparam int unsigned CNT_W = 9;
	localparam int unsigned PRE_W = 2;

	// Request kinds
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_VBLANK = 3'd1;
	localparam logic [2:0] KIND_HBLANK = 3'd2;
	localparam logic [2:0] KIND_WRITE  = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	// I/O register addresses
	localparam logic [15:0] ADDR_IRQ_ENABLE = 16'h4200;
	localparam logic [15:0] ADDR_HCMP_LO    = 16'h4207;
	localparam logic [15:0] ADDR_HCMP_HI    = 16'h4208;
	localparam logic [15:0] ADDR_VCMP_LO    = 16'h4209;
	localparam logic [15:0] ADDR_VCMP_HI    = 16'h420A;
	localparam logic [15:0] ADDR_NMI_FLAG   = 16'h4210;

	// Bits of the interrupt enable byte
	localparam int unsigned EN_NMI_BIT = 7;
	localparam int unsigned EN_V_BIT   = 5;
	localparam int unsigned EN_H_BIT   = 4;

	localparam logic [7:0] NMI_FLAG_BIT7  = 8'h80;
	localparam logic [7:0] NMI_FLAG_AFTER = 8'h01;

	typedef struct packed {
		logic [2:0]  kind;
		logic        level;
		logic [15:0] address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_raise;
		logic       irq_low_drive;
		logic       irq_high_drive;
		logic       hdma_start;
		logic       vblank_notify;
		logic       timer_flag;
		logic [7:0] blank_status;
	} result_t;

endpackage

// ===== rtl/core/hvt_ifs.sv =====
// Request and response channel interfaces of the H/V timer unit.
interface hvt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic        level;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, kind, level, address, write_data, input ready);
	modport sink (input valid, kind, level, address, write_data, output ready);
endinterface

interface hvt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       nmi_raise;
	logic       irq_low_drive;
	logic       irq_high_drive;
	logic       hdma_start;
	logic       vblank_notify;
	logic       timer_flag;
	logic [7:0] blank_status;

	modport source (output valid, read_data, nmi_raise, irq_low_drive, irq_high_drive,
		hdma_start, vblank_notify, timer_flag, blank_status, input ready);
	modport sink (input valid, read_data, nmi_raise, irq_low_drive, irq_high_drive,
		hdma_start, vblank_notify, timer_flag, blank_status, output ready);
endinterface

// ===== rtl/core/hvt_core.sv =====
// Counter, compare, flag and register state with its single-pass update logic.
module hvt_core
	import hvt_pkg::*;
#(
	parameter int unsigned H_WRAP     = 264,
	parameter int unsigned V_WRAP     = 264,
	parameter int unsigned DOT_DIVIDE = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	localparam logic [CNT_W-1:0] H_WRAP_C = CNT_W'(H_WRAP);
	localparam logic [CNT_W-1:0] V_WRAP_C = CNT_W'(V_WRAP);
	localparam logic [PRE_W:0]   DIV_C    = (PRE_W + 1)'(DOT_DIVIDE);

	logic [7:0]       nmi_flag_q, nmi_flag_d;
	logic [7:0]       irq_en_q, irq_en_d;
	logic [CNT_W-1:0] hcmp_q, hcmp_d, vcmp_q, vcmp_d;
	logic [CNT_W-1:0] hcnt_q, hcnt_d, vcnt_q, vcnt_d;
	logic [PRE_W-1:0] pre_q, pre_d;
	logic             timer_q, timer_d;
	logic             vblank_q, vblank_d;
	logic             hblank_q, hblank_d;
	logic             hprev_q, hprev_d;
	logic [7:0]       bus_q, bus_d;

	logic [PRE_W:0]   pre_inc;
	logic [CNT_W-1:0] h_inc, v_inc;
	logic             nmi, irq_low, irq_high, hdma, vnote;

	assign pre_inc = {1'b0, pre_q} + 1'b1;
	assign h_inc   = hcnt_q + 1'b1;
	assign v_inc   = vcnt_q + 1'b1;

	always_comb begin
		nmi_flag_d = nmi_flag_q;
		irq_en_d   = irq_en_q;
		hcmp_d     = hcmp_q;
		vcmp_d     = vcmp_q;
		hcnt_d     = hcnt_q;
		vcnt_d     = vcnt_q;
		pre_d      = pre_q;
		timer_d    = timer_q;
		vblank_d   = vblank_q;
		hblank_d   = hblank_q;
		hprev_d    = hprev_q;
		bus_d      = bus_q;
		nmi        = 1'b0;
		irq_low    = 1'b0;
		irq_high   = 1'b0;
		hdma       = 1'b0;
		vnote      = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (pre_inc < DIV_C) begin
					pre_d = pre_inc[PRE_W-1:0];
				end else begin
					pre_d  = '0;
					hcnt_d = h_inc;
					if (h_inc == hcmp_q && irq_en_q[EN_H_BIT]) begin
						timer_d = 1'b1;
						irq_low = 1'b1;
					end
					if (h_inc == H_WRAP_C) begin
						vcnt_d = v_inc;
						if (v_inc == vcmp_q && irq_en_q[EN_V_BIT]) begin
							timer_d = 1'b1;
							irq_low = 1'b1;
						end
						if (v_inc == V_WRAP_C) begin
							vcnt_d = '0;
						end
						hcnt_d   = '0;
						irq_high = 1'b1;
					end
				end
			end
			KIND_VBLANK: begin
				if (!item.level) begin
					vcnt_d   = '0;
					vblank_d = 1'b0;
				end else begin
					nmi        = !nmi_flag_q[7] && irq_en_q[EN_NMI_BIT];
					nmi_flag_d = nmi_flag_q | NMI_FLAG_BIT7;
					vblank_d   = 1'b1;
				end
				vnote = 1'b1;
			end
			KIND_HBLANK: begin
				if (hprev_q) begin
					hcnt_d   = '0;
					hdma     = 1'b1;
					hblank_d = 1'b0;
				end else begin
					hblank_d = 1'b1;
				end
				hprev_d = item.level;
			end
			KIND_WRITE: begin
				bus_d = item.write_data;
				unique case (item.address)
					ADDR_IRQ_ENABLE: begin
						irq_en_d = item.write_data;
						nmi      = item.write_data[EN_NMI_BIT] && nmi_flag_q[7];
					end
					ADDR_HCMP_LO: hcmp_d = {hcmp_q[CNT_W-1], item.write_data};
					ADDR_HCMP_HI: hcmp_d = {item.write_data[0], hcmp_q[7:0]};
					ADDR_VCMP_LO: vcmp_d = {vcmp_q[CNT_W-1], item.write_data};
					ADDR_VCMP_HI: vcmp_d = {item.write_data[0], vcmp_q[7:0]};
					default: ;
				endcase
			end
			KIND_READ: begin
				if (item.address == ADDR_NMI_FLAG) begin
					bus_d      = nmi_flag_q;
					nmi_flag_d = NMI_FLAG_AFTER;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_flag_q <= '0;
			irq_en_q   <= '0;
			hcmp_q     <= '0;
			vcmp_q     <= '0;
			hcnt_q     <= '0;
			vcnt_q     <= '0;
			pre_q      <= '0;
			timer_q    <= 1'b0;
			vblank_q   <= 1'b0;
			hblank_q   <= 1'b0;
			hprev_q    <= 1'b0;
			bus_q      <= '0;
		end else if (fire) begin
			nmi_flag_q <= nmi_flag_d;
			irq_en_q   <= irq_en_d;
			hcmp_q     <= hcmp_d;
			vcmp_q     <= vcmp_d;
			hcnt_q     <= hcnt_d;
			vcnt_q     <= vcnt_d;
			pre_q      <= pre_d;
			timer_q    <= timer_d;
			vblank_q   <= vblank_d;
			hblank_q   <= hblank_d;
			hprev_q    <= hprev_d;
			bus_q      <= bus_d;
		end
	end

	always_comb begin
		res.read_data      = bus_d;
		res.nmi_raise      = nmi;
		res.irq_low_drive  = irq_low;
		res.irq_high_drive = irq_high;
		res.hdma_start     = hdma;
		res.vblank_notify  = vnote;
		res.timer_flag     = timer_d;
		res.blank_status   = {vblank_d, hblank_d, 6'b0};
	end

endmodule

// ===== rtl/core/hv_timer_nmi_irq_unit.sv =====
// Top level of the H/V counter, timer IRQ and vblank NMI unit.
// Each request is a dot tick, a vblank or hblank edge, or an I/O register
// write or read, and yields exactly one response in request order. Ticks pass
// a divide-by-DOT_DIVIDE prescaler before advancing the 9-bit H count, which
// wraps at H_WRAP and advances the V count (wrapping at V_WRAP); enabled
// compare matches set the sticky timer flag and pulse irq_low_drive, wraps pulse
// irq_high_drive. The unit takes one request per clock unless the output
// register holds a response not yet taken: a request is registered in the
// input stage, is resolved there against the state in a single pass, and its
// response is loaded into the output register once that register is free or
// draining. While a finished response waits for rsp.ready the input stage
// takes one more request and then stalls.
module hv_timer_nmi_irq_unit
	import hvt_pkg::*;
#(
	parameter int unsigned H_WRAP     = 264,
	parameter int unsigned V_WRAP     = 264,
	parameter int unsigned DOT_DIVIDE = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	hvt_req_if.sink   req,
	hvt_rsp_if.source rsp
);

	logic    valid_s1;
	item_t   item_s1;
	logic    rsp_valid_q;
	result_t rsp_q;
	result_t res;
	logic    fire;

	// Resolve the staged request when the output register is free or draining.
	assign fire      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;

	// Input stage: hold the request until it is resolved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{kind: req.kind, level: req.level, address: req.address,
				write_data: req.write_data};
		end
	end

	hvt_core #(
		.H_WRAP     (H_WRAP),
		.V_WRAP     (V_WRAP),
		.DOT_DIVIDE (DOT_DIVIDE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// Output register: load on resolve, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rsp_q.read_data;
	assign rsp.nmi_raise      = rsp_q.nmi_raise;
	assign rsp.irq_low_drive  = rsp_q.irq_low_drive;
	assign rsp.irq_high_drive = rsp_q.irq_high_drive;
	assign rsp.hdma_start     = rsp_q.hdma_start;
	assign rsp.vblank_notify  = rsp_q.vblank_notify;
	assign rsp.timer_flag     = rsp_q.timer_flag;
	assign rsp.blank_status   = rsp_q.blank_status;

endmodule

// ===== rtl/core/hvt_checker.sv =====
// Port-level checker of the H/V timer unit and its bind to the top level.
module hvt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_read_data,
	input logic       rsp_nmi_raise,
	input logic       rsp_irq_low_drive,
	input logic       rsp_irq_high_drive,
	input logic       rsp_hdma_start,
	input logic       rsp_vblank_notify,
	input logic       rsp_timer_flag
);

	logic [1:0] pending_q;
	logic       flag_seen_q;

	// Track requests in flight and whether the sticky timer flag was delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			flag_seen_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
			if (rsp_valid && rsp_ready && rsp_timer_flag) begin
				flag_seen_q <= 1'b1;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
		else $error("response dropped or changed while stalled");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2 && (pending_q != 2'd0 || !rsp_valid))
		else $error("response without request or too many requests in flight");

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && flag_seen_q |-> rsp_timer_flag)
		else $error("timer flag cleared after being reported");

	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_irq_low_drive || rsp_irq_high_drive)
		|-> !rsp_nmi_raise && !rsp_hdma_start && !rsp_vblank_notify)
		else $error("IRQ drive pulse on a non-tick response");

endmodule

bind hv_timer_nmi_irq_unit hvt_checker u_hvt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_read_data      (rsp.read_data),
	.rsp_nmi_raise      (rsp.nmi_raise),
	.rsp_irq_low_drive  (rsp.irq_low_drive),
	.rsp_irq_high_drive (rsp.irq_high_drive),
	.rsp_hdma_start     (rsp.hdma_start),
	.rsp_vblank_notify  (rsp.vblank_notify),
	.rsp_timer_flag     (rsp.timer_flag)
);
